/* src/afbd_pkg.sv */
// Shared types and constants of the anchor-free box decode block.
package afbd_pkg;

  // Largest number of classes in one grid cell; the class counter wraps after it.
  localparam int MAX_CLASSES = 256;
  localparam int CLASS_W     = 8;

  // Field widths.
  localparam int LOGIT_W  = 16;
  localparam int DIST_W   = 16;
  localparam int CELL_W   = 8;
  localparam int SHIFT_W  = 3;
  localparam int EXP_W    = 5;
  localparam int CORNER_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Saturation limits of a corner coordinate.
  localparam logic signed [39:0] CORNER_MAX = 40'sd8388607;
  localparam logic signed [39:0] CORNER_MIN = -40'sd8388608;

  // Reset values of the configuration registers.
  localparam logic signed [LOGIT_W-1:0] THRESHOLD_RESET = '0;
  localparam logic signed [EXP_W-1:0]   EXPONENT_RESET  = -5'sd4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_EXPONENT  = 2'd1
  } cfg_index_t;

  // Running selection of one cell, as it stands after the current item.
  typedef struct packed {
    logic                      found;
    logic signed [LOGIT_W-1:0] best;
    logic [CLASS_W-1:0]        cls;
  } sel_t;

endpackage

/* src/afbd_corner.sv */
// Exact fixed-point decode of one box corner, truncated toward zero and saturated.
module afbd_corner (
  input  logic [afbd_pkg::CELL_W-1:0]          grid_pos,
  input  logic signed [afbd_pkg::DIST_W-1:0]   dist_raw,
  input  logic                                 minus,
  input  logic [afbd_pkg::SHIFT_W-1:0]         sshift,
  input  logic signed [afbd_pkg::EXP_W-1:0]    box_exponent,
  output logic signed [afbd_pkg::CORNER_W-1:0] corner
);
  import afbd_pkg::*;

  logic [EXP_W-1:0]   dist_shamt;
  logic signed [48:0] pos;
  logic signed [47:0] dist_ext;
  logic signed [47:0] dist_sh;
  logic signed [48:0] sum;
  logic signed [55:0] scaled;
  logic signed [39:0] quot;
  logic               round_up;
  logic signed [39:0] quot_tz;

  // Cell center in units of 2^-16; the distance scale 2^(16+exponent) is a shift.
  assign dist_shamt = {~box_exponent[EXP_W-1], box_exponent[EXP_W-2:0]};
  assign pos        = 49'({1'b0, grid_pos, 16'h8000});
  assign dist_ext   = 48'(dist_raw);
  assign dist_sh    = dist_ext <<< dist_shamt;
  assign sum        = minus ? (pos - 49'(dist_sh)) : (pos + 49'(dist_sh));
  assign scaled     = 56'(sum) <<< sshift;

  // Divide by 2^16 with truncation toward zero: floor, plus one for a
  // negative value with a nonzero fraction.
  assign quot     = scaled[55:16];
  assign round_up = scaled[55] && (scaled[15:0] != 16'h0000);
  assign quot_tz  = quot + $signed({39'd0, round_up});

  // Saturate to the signed 24-bit range.
  always_comb begin
    if (quot_tz > CORNER_MAX) begin
      corner = CORNER_MAX[CORNER_W-1:0];
    end else if (quot_tz < CORNER_MIN) begin
      corner = CORNER_MIN[CORNER_W-1:0];
    end else begin
      corner = quot_tz[CORNER_W-1:0];
    end
  end

endmodule

/* src/afbd_class_sel.sv */
// Running best-class selection over the items of one grid cell.
module afbd_class_sel (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic signed [afbd_pkg::LOGIT_W-1:0] logit,
  input  logic                               last,
  input  logic signed [afbd_pkg::LOGIT_W-1:0] threshold,
  output afbd_pkg::sel_t                     sel
);
  import afbd_pkg::*;

  logic signed [LOGIT_W-1:0] running_best;
  logic [CLASS_W-1:0]        running_class;
  logic                      found_any;
  logic [CLASS_W-1:0]        class_counter;
  logic [CLASS_W-1:0]        class_counter_next;
  logic                      pass;
  logic                      take;

  // A logit above threshold wins if it is the first or strictly larger.
  assign pass = logit > threshold;
  assign take = pass && (!found_any || (logit > running_best));

  always_comb begin
    sel.found = found_any || pass;
    sel.best  = take ? logit : running_best;
    sel.cls   = take ? class_counter : running_class;
  end

  // Class counter wraps after the last supported class.
  assign class_counter_next = (class_counter == CLASS_W'(MAX_CLASSES - 1)) ?
                              '0 : class_counter + 1'b1;

  // Cell state advances on each transfer and clears after the last class.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_best  <= '0;
      running_class <= '0;
      found_any     <= 1'b0;
      class_counter <= '0;
    end else if (step) begin
      if (last) begin
        running_best  <= '0;
        running_class <= '0;
        found_any     <= 1'b0;
        class_counter <= '0;
      end else begin
        running_best  <= sel.best;
        running_class <= sel.cls;
        found_any     <= sel.found;
        class_counter <= class_counter_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The cell state is empty after its last class.
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    step && last |=> !found_any && (class_counter == '0))
    else $error("cell state not cleared after last class");

  // With nothing found, the stored best and class stay at zero.
  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    !found_any |-> (running_best == '0) && (running_class == '0))
    else $error("stale selection while nothing found");

  // A winning class records the counter value at which it arrived.
  a_class_from_counter: assert property (@(posedge clk) disable iff (rst)
    step && take && !last |=> running_class == $past(class_counter))
    else $error("winning class does not match counter");
`endif

endmodule

/* src/anchor_free_box_decode_core.sv */
// Top level of the anchor-free box decode block.
//
// Input channel (in_valid/in_ready) carries one class logit per transfer, the
// classes of a grid cell in order, with class_last on the final one; the cell
// position, stride and box distances ride along and are used on the last item.
// Output channel (out_valid/out_ready) carries at most one result per cell:
// best class, its raw logit and four saturated pixel corners.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes the logit
// threshold (index 0) and the box exponent (index 1); other indexes are ignored.
// Throughput is one item per cycle unless a held result stalls the input. An
// item waits in the input register, and its result is loaded into the output
// register when the item moves on, which raises out_valid; the result then
// transfers from the output register. The input register and the output
// register are the only stages, and the compare plus corner shift-add sit
// between them.
// When the receiver stalls, the held result blocks only a last item that would
// produce a new result; other items keep flowing.
// Synchronous reset clears the cell state and both valids and restores the
// register defaults (threshold 0, exponent -4).
module anchor_free_box_decode_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [afbd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [afbd_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [afbd_pkg::LOGIT_W-1:0]   class_logit,
  input  logic                                  class_last,
  input  logic [afbd_pkg::CELL_W-1:0]           cell_col,
  input  logic [afbd_pkg::CELL_W-1:0]           cell_row,
  input  logic [afbd_pkg::SHIFT_W-1:0]          stride_shift,
  input  logic signed [afbd_pkg::DIST_W-1:0]    dist_left,
  input  logic signed [afbd_pkg::DIST_W-1:0]    dist_top,
  input  logic signed [afbd_pkg::DIST_W-1:0]    dist_right,
  input  logic signed [afbd_pkg::DIST_W-1:0]    dist_bottom,
  // Output channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [afbd_pkg::CLASS_W-1:0]          class_id,
  output logic signed [afbd_pkg::LOGIT_W-1:0]   best_logit,
  output logic signed [afbd_pkg::CORNER_W-1:0]  corner_x1,
  output logic signed [afbd_pkg::CORNER_W-1:0]  corner_y1,
  output logic signed [afbd_pkg::CORNER_W-1:0]  corner_x2,
  output logic signed [afbd_pkg::CORNER_W-1:0]  corner_y2
);
  import afbd_pkg::*;

  logic signed [LOGIT_W-1:0] class_threshold_raw;
  logic signed [EXP_W-1:0]   box_exponent;

  logic                      s1_valid;
  logic signed [LOGIT_W-1:0] s1_logit;
  logic                      s1_last;
  logic [CELL_W-1:0]         s1_col;
  logic [CELL_W-1:0]         s1_row;
  logic [SHIFT_W-1:0]        s1_shift;
  logic signed [DIST_W-1:0]  s1_left;
  logic signed [DIST_W-1:0]  s1_top;
  logic signed [DIST_W-1:0]  s1_right;
  logic signed [DIST_W-1:0]  s1_bottom;

  sel_t                       sel;
  logic                       emit;
  logic                       advance;
  logic signed [CORNER_W-1:0] x1;
  logic signed [CORNER_W-1:0] y1;
  logic signed [CORNER_W-1:0] x2;
  logic signed [CORNER_W-1:0] y2;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_threshold_raw <= THRESHOLD_RESET;
      box_exponent        <= EXPONENT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD: class_threshold_raw <= $signed(cfg_data);
        CFG_EXPONENT:  box_exponent <= $signed(cfg_data[EXP_W-1:0]);
        default: ;
      endcase
    end
  end

  // The input stage moves on unless it has a result and the output is held.
  assign emit     = s1_valid && s1_last && sel.found;
  assign advance  = s1_valid && (!emit || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_logit  <= class_logit;
      s1_last   <= class_last;
      s1_col    <= cell_col;
      s1_row    <= cell_row;
      s1_shift  <= stride_shift;
      s1_left   <= dist_left;
      s1_top    <= dist_top;
      s1_right  <= dist_right;
      s1_bottom <= dist_bottom;
    end
  end

  afbd_class_sel u_sel (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .logit     (s1_logit),
    .last      (s1_last),
    .threshold (class_threshold_raw),
    .sel       (sel)
  );

  // Four corner decoders: left and top subtract, right and bottom add.
  afbd_corner u_x1 (
    .grid_pos (s1_col), .dist_raw (s1_left), .minus (1'b1), .sshift (s1_shift),
    .box_exponent (box_exponent), .corner (x1)
  );
  afbd_corner u_y1 (
    .grid_pos (s1_row), .dist_raw (s1_top), .minus (1'b1), .sshift (s1_shift),
    .box_exponent (box_exponent), .corner (y1)
  );
  afbd_corner u_x2 (
    .grid_pos (s1_col), .dist_raw (s1_right), .minus (1'b0), .sshift (s1_shift),
    .box_exponent (box_exponent), .corner (x2)
  );
  afbd_corner u_y2 (
    .grid_pos (s1_row), .dist_raw (s1_bottom), .minus (1'b0), .sshift (s1_shift),
    .box_exponent (box_exponent), .corner (y2)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      class_id   <= sel.cls;
      best_logit <= sel.best;
      corner_x1  <= x1;
      corner_y1  <= y1;
      corner_x2  <= x2;
      corner_y2  <= y2;
    end
  end

`ifndef NO_ASSERTIONS
  // A new result comes only from a last item that moved on.
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(advance && s1_last))
    else $error("result without a last class");

  // A held input item stays in the input register.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("input stage item dropped");

  // A result is blocked only while the output is held.
  a_block_reason: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |-> emit && out_valid && !out_ready)
    else $error("input stage stalled without cause");
`endif

endmodule

/* dv/anchor_free_box_decode_core_tb.sv */
// Self-checking testbench of the anchor-free box decode core.
module anchor_free_box_decode_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import afbd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int N_PHASES       = 8;
  localparam int HOLD_PHASE     = 5;
  localparam int MAX_REPORTS    = 40;

  // Register indexes that the block has no register behind.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // One class logit with the cell fields that ride along.
  typedef struct packed {
    logic signed [LOGIT_W-1:0] logit;
    logic                      last;
    logic [CELL_W-1:0]         col;
    logic [CELL_W-1:0]         row;
    logic [SHIFT_W-1:0]        sh;
    logic signed [DIST_W-1:0]  dl;
    logic signed [DIST_W-1:0]  dt;
    logic signed [DIST_W-1:0]  dr;
    logic signed [DIST_W-1:0]  db;
  } cls_item_t;

  // One decoded detection.
  typedef struct packed {
    logic [CLASS_W-1:0]         cls;
    logic signed [LOGIT_W-1:0]  logit;
    logic signed [CORNER_W-1:0] x1;
    logic signed [CORNER_W-1:0] y1;
    logic signed [CORNER_W-1:0] x2;
    logic signed [CORNER_W-1:0] y2;
  } det_t;

  typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_GIVEN} check_kind_t;

  typedef struct packed {
    check_kind_t kind;
    cls_item_t   it;
    det_t        want;
  } vector_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [LOGIT_W-1:0]   class_logit;
  logic                        class_last;
  logic [CELL_W-1:0]           cell_col;
  logic [CELL_W-1:0]           cell_row;
  logic [SHIFT_W-1:0]          stride_shift;
  logic signed [DIST_W-1:0]    dist_left;
  logic signed [DIST_W-1:0]    dist_top;
  logic signed [DIST_W-1:0]    dist_right;
  logic signed [DIST_W-1:0]    dist_bottom;
  logic                        out_valid;
  logic                        out_ready;
  logic [CLASS_W-1:0]          class_id;
  logic signed [LOGIT_W-1:0]   best_logit;
  logic signed [CORNER_W-1:0]  corner_x1;
  logic signed [CORNER_W-1:0]  corner_y1;
  logic signed [CORNER_W-1:0]  corner_x2;
  logic signed [CORNER_W-1:0]  corner_y2;

  anchor_free_box_decode_core dut (.*);

  // Predictor copy of the registers and of the running cell selection.
  logic signed [LOGIT_W-1:0] thr_q   = THRESHOLD_RESET;
  logic signed [EXP_W-1:0]   exp_q   = EXPONENT_RESET;
  logic signed [LOGIT_W-1:0] best_q  = '0;
  logic [CLASS_W-1:0]        cls_q   = '0;
  logic                      found_q = 1'b0;
  logic [CLASS_W-1:0]        count_q = '0;

  det_t    pending_dets[$];
  vector_t dir_tab[$];

  int tx_idle   = 0;
  int rx_stall  = 0;
  int hold_left = 0;
  int n_err     = 0;
  int n_items   = 0;
  int n_cells   = 0;
  int n_checked = 0;
  int n_cfg     = 0;
  int n_wrap    = 0;
  int n_sat     = 0;
  int idle_cycles = 0;

  int ph_thr[N_PHASES];
  int ph_exp[N_PHASES];
  int ph_tx[N_PHASES];
  int ph_rx[N_PHASES];
  int ph_items[N_PHASES];

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One box corner in units of 2^-16, scaled by the stride, truncated and saturated.
  function automatic logic signed [CORNER_W-1:0] box_corner(
      input logic [CELL_W-1:0] grid_pos, input logic signed [DIST_W-1:0] dist_raw,
      input bit minus, input logic [SHIFT_W-1:0] sh);
    longint pos;
    longint d;
    longint v;
    int     scale;
    pos   = longint'(grid_pos) * 65536 + 32768;
    scale = 16 + int'(exp_q);
    d     = longint'(dist_raw) * (longint'(1) << scale);
    v     = minus ? pos - d : pos + d;
    v     = v * (longint'(1) << sh);
    v     = v / 65536;
    if (v > 8388607) begin
      v = 8388607;
      n_sat++;
    end else if (v < -8388608) begin
      v = -8388608;
      n_sat++;
    end
    return v[CORNER_W-1:0];
  endfunction

  // Advance the cell selection by one logit; returns 1 when a detection comes out.
  function automatic bit decode_step(input cls_item_t it, output det_t d);
    bit hit;
    hit = 1'b0;
    d   = '0;
    if ($signed(it.logit) > $signed(thr_q)) begin
      if (!found_q || $signed(it.logit) > $signed(best_q)) begin
        best_q  = it.logit;
        cls_q   = count_q;
        found_q = 1'b1;
      end
    end
    count_q = count_q + 1'b1;
    if (it.last) begin
      if (found_q) begin
        d.cls   = cls_q;
        d.logit = best_q;
        d.x1    = box_corner(it.col, it.dl, 1'b1, it.sh);
        d.y1    = box_corner(it.row, it.dt, 1'b1, it.sh);
        d.x2    = box_corner(it.col, it.dr, 1'b0, it.sh);
        d.y2    = box_corner(it.row, it.db, 1'b0, it.sh);
        hit     = 1'b1;
      end
      best_q  = '0;
      cls_q   = '0;
      found_q = 1'b0;
      count_q = '0;
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_err < MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
    n_err++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want)
      report_mismatch($sformatf("detection %0d %s got %0d want %0d", n_checked, name, got, want));
  endtask

  // Directed table rows; given_det turns the last row into one with a typed-in result.
  task automatic add_vector(input check_kind_t kind, input int logit, input bit last,
      input int col, input int row, input int sh, input int dl, input int dt, input int dr,
      input int db);
    vector_t v;
    v          = '0;
    v.kind     = kind;
    v.it.logit = logit[LOGIT_W-1:0];
    v.it.last  = last;
    v.it.col   = col[CELL_W-1:0];
    v.it.row   = row[CELL_W-1:0];
    v.it.sh    = sh[SHIFT_W-1:0];
    v.it.dl    = dl[DIST_W-1:0];
    v.it.dt    = dt[DIST_W-1:0];
    v.it.dr    = dr[DIST_W-1:0];
    v.it.db    = db[DIST_W-1:0];
    dir_tab = {dir_tab, v};
  endtask

  task automatic given_det(input int cls, input int logit, input int x1, input int y1,
      input int x2, input int y2);
    vector_t v;
    v            = dir_tab.pop_back();
    v.kind       = CHECK_GIVEN;
    v.want.cls   = cls[CLASS_W-1:0];
    v.want.logit = logit[LOGIT_W-1:0];
    v.want.x1    = x1[CORNER_W-1:0];
    v.want.y1    = y1[CORNER_W-1:0];
    v.want.x2    = x2[CORNER_W-1:0];
    v.want.y2    = y2[CORNER_W-1:0];
    dir_tab = {dir_tab, v};
  endtask

  // Offer one logit after a random gap and wait for its transfer.
  task automatic send_item(input cls_item_t it, output bit hit, output det_t d);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    class_logit  <= it.logit;
    class_last   <= it.last;
    cell_col     <= it.col;
    cell_row     <= it.row;
    stride_shift <= it.sh;
    dist_left    <= it.dl;
    dist_top     <= it.dt;
    dist_right   <= it.dr;
    dist_bottom  <= it.db;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
    hit = decode_step(it, d);
  endtask

  // Register write; valid stays high so that writes can follow back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    n_cfg++;
    case (idx)
      CFG_THRESHOLD: thr_q = data;
      CFG_EXPONENT:  exp_q = data[EXP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int thr, input int expo, input bit spare);
    logic [CFG_DATA_W-1:0] data;
    data = thr[CFG_DATA_W-1:0];
    write_reg(CFG_THRESHOLD, data);
    // Upper bits of the exponent write are junk that the block must drop.
    data = CFG_DATA_W'($urandom);
    data[EXP_W-1:0] = expo[EXP_W-1:0];
    write_reg(CFG_EXPONENT, data);
    if (spare) write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every detection, then let the pipeline empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_dets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [LOGIT_W-1:0] rand_logit();
    int v;
    case ($urandom_range(9))
      0:       v = $urandom_range(65535);
      1:       v = $urandom_range(1) ? 32767 : -32768;
      2:       v = int'(thr_q) + int'($urandom_range(4)) - 2;
      default: v = int'($urandom_range(255)) - 128;
    endcase
    return v[LOGIT_W-1:0];
  endfunction

  function automatic logic signed [DIST_W-1:0] rand_dist();
    int v;
    case ($urandom_range(7))
      0:       v = $urandom_range(65535);
      1:       v = $urandom_range(1) ? 32767 : -32768;
      default: v = int'($urandom_range(511)) - 256;
    endcase
    return v[DIST_W-1:0];
  endfunction

  task automatic send_cell(input int n);
    cls_item_t it;
    bit        hit;
    det_t      d;
    for (int k = 0; k < n; k++) begin
      it.logit = rand_logit();
      it.last  = (k == n - 1);
      it.col   = CELL_W'($urandom);
      it.row   = CELL_W'($urandom);
      it.sh    = SHIFT_W'($urandom);
      it.dl    = rand_dist();
      it.dt    = rand_dist();
      it.dr    = rand_dist();
      it.db    = rand_dist();
      send_item(it, hit, d);
      if (hit) pending_dets = {pending_dets, d};
    end
    n_cells++;
  endtask

  function automatic int rand_cell_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(1, 4);
    if (r < 90) return $urandom_range(5, 16);
    return $urandom_range(17, 64);
  endfunction

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall);
      end
    end
  end

  // Compare every result transfer with the oldest pending detection.
  always @(posedge clk) begin
    det_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_dets.size() == 0) begin
        report_mismatch($sformatf("unexpected detection class %0d logit %0d",
                                  class_id, best_logit));
      end else begin
        w = pending_dets.pop_front();
        check_field("class_id", class_id, w.cls);
        check_field("best_logit", $signed(best_logit), $signed(w.logit));
        check_field("corner_x1", $signed(corner_x1), $signed(w.x1));
        check_field("corner_y1", $signed(corner_y1), $signed(w.y1));
        check_field("corner_x2", $signed(corner_x2), $signed(w.x2));
        check_field("corner_y2", $signed(corner_y2), $signed(w.y2));
      end
      n_checked++;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("anchor_free_box_decode_core_tb failed");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    int        start;
    bit        hit;
    det_t      d;
    vector_t   v;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    class_logit  = '0;
    class_last   = 1'b0;
    cell_col     = '0;
    cell_row     = '0;
    stride_shift = '0;
    dist_left    = '0;
    dist_top     = '0;
    dist_right   = '0;
    dist_bottom  = '0;

    // Directed vectors, run with the reset register values.
    // A single class just above threshold at the grid origin.
    add_vector(CHECK_MODEL, 5, 1, 0, 0, 0, 0, 0, 0, 0);
    given_det(0, 5, 0, 0, 0, 0);
    // A logit equal to the threshold does not pass.
    add_vector(CHECK_NONE, 0, 1, 0, 0, 0, 0, 0, 0, 0);
    // Distance 16 at exponent -4 is one grid unit; stride 8.
    add_vector(CHECK_MODEL, 100, 1, 10, 20, 3, 16, 16, 16, 16);
    given_det(0, 100, 76, 156, 92, 172);
    // On a tie the earlier class wins.
    add_vector(CHECK_NONE, 7, 0, 1, 2, 1, 0, 0, 0, 0);
    add_vector(CHECK_NONE, 9, 0, 1, 2, 1, 0, 0, 0, 0);
    add_vector(CHECK_MODEL, 9, 1, 1, 2, 1, 0, 0, 0, 0);
    given_det(1, 9, 3, 5, 3, 5);
    // Negative and fractional corners truncate toward zero.
    add_vector(CHECK_MODEL, 1, 1, 0, 0, 0, 20, 40, 20, 40);
    given_det(0, 1, 0, -2, 1, 3);
    // No class passes: no detection, state still clears.
    add_vector(CHECK_NONE, -5, 0, 0, 0, 0, 0, 0, 0, 0);
    add_vector(CHECK_NONE, 0, 1, 0, 0, 0, 0, 0, 0, 0);
    // Field extremes.
    add_vector(CHECK_MODEL, 3, 0, 0, 0, 0, 0, 0, 0, 0);
    add_vector(CHECK_MODEL, 32767, 0, 0, 0, 0, 0, 0, 0, 0);
    add_vector(CHECK_MODEL, -32768, 1, 255, 255, 7, -32768, 32767, 32767, -32768);
    add_vector(CHECK_MODEL, -32768, 0, 0, 0, 0, 0, 0, 0, 0);
    add_vector(CHECK_MODEL, 32767, 1, 0, 255, 0, 32767, -32768, -32768, 32767);
    // A later larger logit replaces the best; a later tie does not.
    add_vector(CHECK_MODEL, 1, 0, 128, 64, 5, 0, 0, 0, 0);
    add_vector(CHECK_MODEL, 50, 0, 128, 64, 5, 0, 0, 0, 0);
    add_vector(CHECK_MODEL, 2, 0, 128, 64, 5, 0, 0, 0, 0);
    add_vector(CHECK_MODEL, 50, 1, 128, 64, 5, 1234, -77, 300, -4000);
    // Far column at the largest stride.
    add_vector(CHECK_MODEL, 127, 1, 255, 0, 7, 0, 0, 0, 0);
    given_det(0, 127, 32704, 64, 32704, 64);

    // Random phases: threshold, exponent, sender idle, receiver stall, items.
    ph_thr[0] = 0;       ph_exp[0] = -4;  ph_tx[0] = 0;  ph_rx[0] = 0;  ph_items[0] = 220;
    ph_thr[1] = -32768;  ph_exp[1] = -15; ph_tx[1] = 82; ph_rx[1] = 0;  ph_items[1] = 150;
    ph_thr[2] = 32767;   ph_exp[2] = 0;   ph_tx[2] = 0;  ph_rx[2] = 82; ph_items[2] = 60;
    ph_thr[3] = 20;      ph_exp[3] = 15;  ph_tx[3] = 0;  ph_rx[3] = 82; ph_items[3] = 150;
    ph_thr[4] = -100;    ph_exp[4] = -16; ph_tx[4] = 36; ph_rx[4] = 36; ph_items[4] = 150;
    ph_thr[5] = int'($urandom_range(200)) - 100;
    ph_exp[5] = -int'($urandom_range(15));
    ph_tx[5] = 0;  ph_rx[5] = 0;  ph_items[5] = 120;
    ph_thr[6] = int'($urandom_range(200)) - 100;
    ph_exp[6] = int'($urandom_range(31)) - 16;
    ph_tx[6] = 82; ph_rx[6] = 82; ph_items[6] = 150;
    ph_thr[7] = 0;       ph_exp[7] = -4;  ph_tx[7] = 0;  ph_rx[7] = 0;  ph_items[7] = 100;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    foreach (dir_tab[i]) begin
      v = dir_tab[i];
      send_item(v.it, hit, d);
      case (v.kind)
        CHECK_MODEL: if (hit) pending_dets = {pending_dets, d};
        CHECK_GIVEN: pending_dets = {pending_dets, v.want};
        default: ;
      endcase
    end
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      configure(ph_thr[p], ph_exp[p], (p % 3) == 2);
      tx_idle  = ph_tx[p];
      rx_stall = ph_rx[p];
      // Long receiver hold-off while the sender keeps offering.
      if (p == HOLD_PHASE) hold_left = HOLD_CYCLES;
      start = n_items;
      // A cell longer than the class counter, so the counter wraps.
      if (p == 0) begin
        send_cell(MAX_CLASSES + $urandom_range(1, 40));
        n_wrap++;
      end
      while (n_items - start < ph_items[p]) begin
        send_cell(rand_cell_len());
      end
      drain();
    end

    if (pending_dets.size() != 0)
      report_mismatch($sformatf("%0d detections never arrived", pending_dets.size()));

    $display("covered %0d logits in %0d cells (%0d with counter wrap), %0d register writes",
             n_items, n_cells, n_wrap, n_cfg);
    $display("checked %0d detections, %0d saturated corners, %0d mismatches",
             n_checked, n_sat, n_err);
    if (n_err == 0) begin
      $display("anchor_free_box_decode_core_tb passed");
    end else begin
      $display("anchor_free_box_decode_core_tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/afbd_pkg.sv
src/afbd_corner.sv
src/afbd_class_sel.sv
src/anchor_free_box_decode_core.sv
dv/anchor_free_box_decode_core_tb.sv
